FILE: sv/selective_repeat_receive_window_core_defines.svh
// Assertion macros for the selective-repeat receive window.
// Needs the clock and reset names of the including module: clock, reset.
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define SRW_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("srw assertion failed");

// overlapping implication
`define SRW_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("srw implication failed");

// next-cycle implication
`define SRW_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("srw next-cycle implication failed");

`else

`define SRW_ASSERT(name, prop)
`define SRW_ASSERT_IMP(name, ante, cons)
`define SRW_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: sv/srw_pkg.sv
// Shared constants, types and functions of the selective-repeat receive window.
// No dependencies.
package srw_pkg;

   localparam int WINDOW_SLOTS = 8;
   localparam int FULL_PAYLOAD = 1024;
   localparam int SEQ_SPACE    = 65536;

   localparam int SEQ_W  = 16;
   localparam int LEN_W  = 11;
   localparam int TAG_W  = 8;
   localparam int SLOT_W = $clog2(WINDOW_SLOTS);
   localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);

   // advance of a slot's expected number on release, already reduced
   localparam int SEQ_ADVANCE = (WINDOW_SLOTS * FULL_PAYLOAD) % SEQ_SPACE;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SCAN,
      ST_STATUS,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic             fill_en;
      logic             free_en;
      logic [LEN_W-1:0] size;
      logic [TAG_W-1:0] tag;
   } slot_wr_type;

   typedef struct packed {
      logic [SEQ_W-1:0] exp_seq;
      logic             rcvd;
      logic [LEN_W-1:0] size;
      logic [TAG_W-1:0] tag;
   } slot_rd_type;

   function automatic logic [SEQ_W-1:0] slot_reset_seq(input int k);
      int v;
      v = (k * FULL_PAYLOAD) % SEQ_SPACE;
      return SEQ_W'(v);
   endfunction

endpackage

FILE: sv/selective_repeat_receive_window_core.sv
// Selective-repeat receive window, receiver side.
// Request channel (req_valid/req_stall): one arrived packet per transfer with its
// byte-offset sequence number, length and payload handle.
// Response channel (rsp_valid/rsp_stall): one status transfer (kind 0) per
// packet, then one delivery transfer (kind 1) per frame released in order;
// rsp_last marks the final transfer of a packet.
// Timing: the slot search walks the window from the head, one slot a cycle,
// until a match or until every slot is tried. On a match a second pass over all
// WINDOW_SLOTS slots measures the received run at the head. Then the status
// and each delivery go out in turn through the result register. A dropped
// packet skips the scan and gives its status only; only a match at the head
// releases frames. The block takes no new packet until the last one is through:
// req_stall stays high until its last result is loaded. The single slot read
// index sets the pace of the search and the scan.
// Reset: synchronous; the window restarts with slot k expecting k times the
// full payload, nothing received, head at slot zero and no short frame seen.
// A stalled result holds; the block waits on rsp_stall before loading the next.
module selective_repeat_receive_window_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [srw_pkg::SEQ_W-1:0]   req_seq_no,
   input  logic [srw_pkg::LEN_W-1:0]   req_data_len,
   input  logic [srw_pkg::TAG_W-1:0]   req_payload_tag,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_kind,
   output logic                        rsp_accepted,
   output logic [srw_pkg::SEQ_W-1:0]   rsp_frame_seq,
   output logic [srw_pkg::LEN_W-1:0]   rsp_frame_size,
   output logic [srw_pkg::TAG_W-1:0]   rsp_frame_tag,
   output logic                        rsp_transfer_done,
   output logic                        rsp_last
);

   logic [srw_pkg::SLOT_W-1:0] slot_idx;
   srw_pkg::slot_wr_type       slot_wr;
   srw_pkg::slot_rd_type       slot_rd;

   srw_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_seq_no        (req_seq_no),
      .req_data_len      (req_data_len),
      .req_payload_tag   (req_payload_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_accepted      (rsp_accepted),
      .rsp_frame_seq     (rsp_frame_seq),
      .rsp_frame_size    (rsp_frame_size),
      .rsp_frame_tag     (rsp_frame_tag),
      .rsp_transfer_done (rsp_transfer_done),
      .rsp_last          (rsp_last),
      .slot_idx          (slot_idx),
      .slot_wr           (slot_wr),
      .slot_rd           (slot_rd)
   );

   srw_slots u_slots (
      .clock (clock),
      .reset (reset),
      .idx   (slot_idx),
      .wr    (slot_wr),
      .rd    (slot_rd)
   );

endmodule

FILE: sv/srw_slots.sv
// Window slot storage: expected numbers, received flags, sizes and tags.
// One read/write index per cycle; depends on srw_pkg.
module srw_slots (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [srw_pkg::SLOT_W-1:0]       idx,
   input  srw_pkg::slot_wr_type             wr,
   output srw_pkg::slot_rd_type             rd
);

   logic [srw_pkg::SEQ_W-1:0] exp_ff  [srw_pkg::WINDOW_SLOTS];
   logic                      rcvd_ff [srw_pkg::WINDOW_SLOTS];
   logic [srw_pkg::LEN_W-1:0] size_ff [srw_pkg::WINDOW_SLOTS];
   logic [srw_pkg::TAG_W-1:0] tag_ff  [srw_pkg::WINDOW_SLOTS];

   logic [srw_pkg::SEQ_W:0]   rearm_sum;
   logic [srw_pkg::SEQ_W-1:0] rearm_seq;

   // sum stays below twice the sequence space, so one subtract wraps it
   always_comb begin
      rearm_sum = {1'b0, exp_ff[idx]} + (srw_pkg::SEQ_W + 1)'(srw_pkg::SEQ_ADVANCE);
      if (rearm_sum >= (srw_pkg::SEQ_W + 1)'(srw_pkg::SEQ_SPACE)) begin
         rearm_seq = srw_pkg::SEQ_W'(rearm_sum - (srw_pkg::SEQ_W + 1)'(srw_pkg::SEQ_SPACE));
      end else begin
         rearm_seq = srw_pkg::SEQ_W'(rearm_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < srw_pkg::WINDOW_SLOTS; k++) begin
            exp_ff[k]  <= srw_pkg::slot_reset_seq(k);
            rcvd_ff[k] <= 1'b0;
            size_ff[k] <= '0;
         end
      end else if (wr.fill_en) begin
         rcvd_ff[idx] <= 1'b1;
         size_ff[idx] <= wr.size;
      end else if (wr.free_en) begin
         rcvd_ff[idx] <= 1'b0;
         size_ff[idx] <= '0;
         exp_ff[idx]  <= rearm_seq;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.fill_en) begin
         tag_ff[idx] <= wr.tag;
      end
   end

   assign rd.exp_seq = exp_ff[idx];
   assign rd.rcvd    = rcvd_ff[idx];
   assign rd.size    = size_ff[idx];
   assign rd.tag     = tag_ff[idx];

endmodule

FILE: sv/srw_seq.sv
// Sequencer of the receive window: slot search, head-run scan, status and
// in-order delivery through one result register. Depends on srw_pkg, srw_slots data.
`include "selective_repeat_receive_window_core_defines.svh"

module srw_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [srw_pkg::SEQ_W-1:0]   req_seq_no,
   input  logic [srw_pkg::LEN_W-1:0]   req_data_len,
   input  logic [srw_pkg::TAG_W-1:0]   req_payload_tag,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_kind,
   output logic                        rsp_accepted,
   output logic [srw_pkg::SEQ_W-1:0]   rsp_frame_seq,
   output logic [srw_pkg::LEN_W-1:0]   rsp_frame_size,
   output logic [srw_pkg::TAG_W-1:0]   rsp_frame_tag,
   output logic                        rsp_transfer_done,
   output logic                        rsp_last,
   output logic [srw_pkg::SLOT_W-1:0]  slot_idx,
   output srw_pkg::slot_wr_type        slot_wr,
   input  srw_pkg::slot_rd_type        slot_rd
);

   srw_pkg::state_type state_ff, state_in;

   logic [srw_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [srw_pkg::CNT_W-1:0]  run_cnt_ff, run_cnt_in;
   logic [srw_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic [srw_pkg::SLOT_W-1:0] head_ff, head_in;
   logic [srw_pkg::SEQ_W-1:0]  seq_ff, seq_in;
   logic [srw_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [srw_pkg::TAG_W-1:0]  tag_ff, tag_in;
   logic hit_ff, hit_in;
   logic in_run_ff, in_run_in;
   logic run_short_ff, run_short_in;
   logic nonempty_ff, nonempty_in;
   logic short_seen_ff, short_seen_in;

   logic                       out_valid_ff, out_valid_in;
   logic                       out_kind_ff, out_kind_in;
   logic                       out_acc_ff, out_acc_in;
   logic [srw_pkg::SEQ_W-1:0]  out_seq_ff, out_seq_in;
   logic [srw_pkg::LEN_W-1:0]  out_size_ff, out_size_in;
   logic [srw_pkg::TAG_W-1:0]  out_tag_ff, out_tag_in;
   logic                       out_done_ff, out_done_in;
   logic                       out_last_ff, out_last_in;

   logic                       match;
   logic                       last_step;
   logic                       out_free;
   logic                       size_short;
   logic                       status_last;
   logic [srw_pkg::SLOT_W-1:0] idx_next;

   // shared compare unit: one slot per cycle
   assign match       = (slot_rd.exp_seq == seq_ff);
   assign size_short  = (32'(slot_rd.size) != 32'(srw_pkg::FULL_PAYLOAD));
   assign last_step   = (cnt_ff == srw_pkg::CNT_W'(srw_pkg::WINDOW_SLOTS - 1));
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign status_last = !hit_ff || (run_cnt_ff == '0);
   assign idx_next    = (idx_ff == srw_pkg::SLOT_W'(srw_pkg::WINDOW_SLOTS - 1)) ?
                        '0 : idx_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srw_pkg::ST_IDLE: begin
            if (req_valid) state_in = srw_pkg::ST_SEARCH;
         end
         srw_pkg::ST_SEARCH: begin
            if (match) state_in = srw_pkg::ST_SCAN;
            else if (last_step) state_in = srw_pkg::ST_STATUS;
         end
         srw_pkg::ST_SCAN: begin
            if (last_step) state_in = srw_pkg::ST_STATUS;
         end
         srw_pkg::ST_STATUS: begin
            if (out_free) state_in = status_last ? srw_pkg::ST_IDLE : srw_pkg::ST_DELIVER;
         end
         srw_pkg::ST_DELIVER: begin
            if (out_free && cnt_ff == srw_pkg::CNT_W'(1)) state_in = srw_pkg::ST_IDLE;
         end
         default: state_in = srw_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_in        = cnt_ff;
      run_cnt_in    = run_cnt_ff;
      idx_in        = idx_ff;
      head_in       = head_ff;
      seq_in        = seq_ff;
      len_in        = len_ff;
      tag_in        = tag_ff;
      hit_in        = hit_ff;
      in_run_in     = in_run_ff;
      run_short_in  = run_short_ff;
      nonempty_in   = nonempty_ff;
      short_seen_in = short_seen_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_kind_in   = out_kind_ff;
      out_acc_in    = out_acc_ff;
      out_seq_in    = out_seq_ff;
      out_size_in   = out_size_ff;
      out_tag_in    = out_tag_ff;
      out_done_in   = out_done_ff;
      out_last_in   = out_last_ff;
      slot_wr       = '0;
      req_stall     = 1'b1;

      case (state_ff)
         srw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               seq_in       = req_seq_no;
               len_in       = req_data_len;
               tag_in       = req_payload_tag;
               idx_in       = head_ff;
               cnt_in       = '0;
               hit_in       = 1'b0;
               in_run_in    = 1'b1;
               run_cnt_in   = '0;
               run_short_in = 1'b0;
               nonempty_in  = 1'b0;
            end
         end
         srw_pkg::ST_SEARCH: begin
            if (match) begin
               slot_wr.fill_en = 1'b1;
               slot_wr.size    = len_ff;
               slot_wr.tag     = tag_ff;
               hit_in          = 1'b1;
               idx_in          = head_ff;
               cnt_in          = '0;
            end else begin
               idx_in = idx_next;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         srw_pkg::ST_SCAN: begin
            // count the received run at the head; anything received past it stays
            if (in_run_ff && slot_rd.rcvd) begin
               run_cnt_in   = run_cnt_ff + 1'b1;
               run_short_in = run_short_ff | size_short;
            end else begin
               in_run_in = 1'b0;
               if (slot_rd.rcvd) nonempty_in = 1'b1;
            end
            idx_in = idx_next;
            cnt_in = cnt_ff + 1'b1;
         end
         srw_pkg::ST_STATUS: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = 1'b0;
               out_acc_in    = hit_ff;
               out_seq_in    = '0;
               out_size_in   = '0;
               out_tag_in    = '0;
               out_done_in   = hit_ff && (short_seen_ff || run_short_ff) && !nonempty_ff;
               out_last_in   = status_last;
               short_seen_in = short_seen_ff | run_short_ff;
               cnt_in        = run_cnt_ff;
            end
         end
         srw_pkg::ST_DELIVER: begin
            if (out_free) begin
               out_valid_in    = 1'b1;
               out_kind_in     = 1'b1;
               out_acc_in      = 1'b0;
               out_seq_in      = slot_rd.exp_seq;
               out_size_in     = slot_rd.size;
               out_tag_in      = slot_rd.tag;
               out_done_in     = 1'b0;
               out_last_in     = (cnt_ff == srw_pkg::CNT_W'(1));
               slot_wr.free_en = 1'b1;
               head_in         = idx_next;
               idx_in          = idx_next;
               cnt_in          = cnt_ff - 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srw_pkg::ST_IDLE;
         cnt_ff        <= '0;
         run_cnt_ff    <= '0;
         idx_ff        <= '0;
         head_ff       <= '0;
         hit_ff        <= 1'b0;
         in_run_ff     <= 1'b0;
         run_short_ff  <= 1'b0;
         nonempty_ff   <= 1'b0;
         short_seen_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         run_cnt_ff    <= run_cnt_in;
         idx_ff        <= idx_in;
         head_ff       <= head_in;
         hit_ff        <= hit_in;
         in_run_ff     <= in_run_in;
         run_short_ff  <= run_short_in;
         nonempty_ff   <= nonempty_in;
         short_seen_ff <= short_seen_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      len_ff      <= len_in;
      tag_ff      <= tag_in;
      out_kind_ff <= out_kind_in;
      out_acc_ff  <= out_acc_in;
      out_seq_ff  <= out_seq_in;
      out_size_ff <= out_size_in;
      out_tag_ff  <= out_tag_in;
      out_done_ff <= out_done_in;
      out_last_ff <= out_last_in;
   end

   assign slot_idx          = idx_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_accepted      = out_acc_ff;
   assign rsp_frame_seq     = out_seq_ff;
   assign rsp_frame_size    = out_size_ff;
   assign rsp_frame_tag     = out_tag_ff;
   assign rsp_transfer_done = out_done_ff;
   assign rsp_last          = out_last_ff;

   `SRW_ASSERT_IMP(a_deliver_fields, rsp_valid && rsp_kind, !rsp_accepted && !rsp_transfer_done)
   `SRW_ASSERT_IMP(a_done_needs_accept, rsp_valid && !rsp_kind && rsp_transfer_done, rsp_accepted)
   `SRW_ASSERT(a_deliver_count, (state_ff != srw_pkg::ST_DELIVER) || (cnt_ff != '0))
   `SRW_ASSERT_IMP(a_deliver_at_head, state_ff == srw_pkg::ST_DELIVER, idx_ff == head_ff)
   `SRW_ASSERT_NEXT(a_accept_starts, req_valid && !req_stall, state_ff == srw_pkg::ST_SEARCH)

endmodule

FILE: dv/srw_window_checker.sv
// Checker for the selective-repeat receive window: follows both channels,
// predicts every result from the accepted packets and compares field by field.
// Depends on srw_pkg for widths and window constants.
`timescale 1ns / 100ps

module srw_window_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [srw_pkg::SEQ_W-1:0]   req_seq_no,
   input  logic [srw_pkg::LEN_W-1:0]   req_data_len,
   input  logic [srw_pkg::TAG_W-1:0]   req_payload_tag,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        rsp_kind,
   input  logic                        rsp_accepted,
   input  logic [srw_pkg::SEQ_W-1:0]   rsp_frame_seq,
   input  logic [srw_pkg::LEN_W-1:0]   rsp_frame_size,
   input  logic [srw_pkg::TAG_W-1:0]   rsp_frame_tag,
   input  logic                        rsp_transfer_done,
   input  logic                        rsp_last,
   output int                          fail_count,
   output int                          pending_results
);

   localparam logic KIND_STATUS   = 1'b0;
   localparam logic KIND_DELIVERY = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic                      accepted;
      logic [srw_pkg::SEQ_W-1:0] frame_seq;
      logic [srw_pkg::LEN_W-1:0] frame_size;
      logic [srw_pkg::TAG_W-1:0] frame_tag;
      logic                      transfer_done;
      logic                      last;
   } frame_result_type;

   // predicted window
   logic [srw_pkg::SEQ_W-1:0]        slot_seq  [srw_pkg::WINDOW_SLOTS];
   logic [srw_pkg::LEN_W-1:0]        slot_size [srw_pkg::WINDOW_SLOTS];
   logic [srw_pkg::TAG_W-1:0]        slot_tag  [srw_pkg::WINDOW_SLOTS];
   logic [srw_pkg::WINDOW_SLOTS-1:0] slot_rcvd;
   logic [srw_pkg::SLOT_W-1:0]       head_slot;
   logic                             short_seen;

   frame_result_type due_results[$];
   int failures = 0;

   task automatic report_failure(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      failures++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_failure($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // one arrived packet: store it, release the received run at the head
   task automatic predict_arrival(input logic [srw_pkg::SEQ_W-1:0] seq,
                                  input logic [srw_pkg::LEN_W-1:0] len,
                                  input logic [srw_pkg::TAG_W-1:0] tag);
      frame_result_type status;
      frame_result_type frame;
      frame_result_type released[$];
      logic [srw_pkg::SLOT_W-1:0] slot;
      logic matched;
      logic releasing;
      matched = 1'b0;
      for (int i = 0; i < srw_pkg::WINDOW_SLOTS; i++) begin
         slot = srw_pkg::SLOT_W'((head_slot + i) % srw_pkg::WINDOW_SLOTS);
         if (!matched && slot_seq[slot] == seq) begin
            slot_size[slot] = len;
            slot_tag[slot]  = tag;
            slot_rcvd[slot] = 1'b1;
            matched = 1'b1;
         end
      end
      releasing = matched;
      for (int i = 0; i < srw_pkg::WINDOW_SLOTS; i++) begin
         if (releasing && slot_rcvd[head_slot]) begin
            frame = '0;
            frame.kind       = KIND_DELIVERY;
            frame.frame_seq  = slot_seq[head_slot];
            frame.frame_size = slot_size[head_slot];
            frame.frame_tag  = slot_tag[head_slot];
            released.push_back(frame);
            if (slot_size[head_slot] != srw_pkg::FULL_PAYLOAD)
               short_seen = 1'b1;
            slot_rcvd[head_slot] = 1'b0;
            slot_size[head_slot] = '0;
            slot_tag[head_slot]  = '0;
            slot_seq[head_slot]  = srw_pkg::SEQ_W'((slot_seq[head_slot] +
                                   srw_pkg::WINDOW_SLOTS * srw_pkg::FULL_PAYLOAD)
                                   % srw_pkg::SEQ_SPACE);
            head_slot = srw_pkg::SLOT_W'((head_slot + 1) % srw_pkg::WINDOW_SLOTS);
         end else begin
            releasing = 1'b0;
         end
      end
      status = '0;
      status.kind          = KIND_STATUS;
      status.accepted      = matched;
      status.transfer_done = matched && short_seen && (slot_rcvd == '0);
      status.last          = (released.size() == 0);
      due_results.push_back(status);
      for (int i = 0; i < released.size(); i++) begin
         frame = released[i];
         frame.last = (i == released.size() - 1);
         due_results.push_back(frame);
      end
   endtask

   always @(posedge clock) begin : watch
      frame_result_type oldest;
      if (reset) begin
         for (int k = 0; k < srw_pkg::WINDOW_SLOTS; k++) begin
            slot_seq[k]  = srw_pkg::SEQ_W'((k * srw_pkg::FULL_PAYLOAD) % srw_pkg::SEQ_SPACE);
            slot_size[k] = '0;
            slot_tag[k]  = '0;
         end
         slot_rcvd  = '0;
         head_slot  = '0;
         short_seen = 1'b0;
         due_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               report_failure($sformatf("result with nothing due: kind %0d seq %0d",
                                        rsp_kind, rsp_frame_seq));
            end else begin
               oldest = due_results.pop_front();
               compare_field("kind", 32'(rsp_kind), 32'(oldest.kind));
               compare_field("accepted", 32'(rsp_accepted), 32'(oldest.accepted));
               compare_field("frame_seq", 32'(rsp_frame_seq), 32'(oldest.frame_seq));
               compare_field("frame_size", 32'(rsp_frame_size), 32'(oldest.frame_size));
               compare_field("frame_tag", 32'(rsp_frame_tag), 32'(oldest.frame_tag));
               compare_field("transfer_done", 32'(rsp_transfer_done),
                             32'(oldest.transfer_done));
               compare_field("last", 32'(rsp_last), 32'(oldest.last));
            end
         end
         if (req_valid && !req_stall)
            predict_arrival(req_seq_no, req_data_len, req_payload_tag);
      end
      pending_results <= due_results.size();
      fail_count      <= failures;
   end

endmodule

FILE: dv/tb_selective_repeat_receive_window_core.sv
// Testbench top for the selective-repeat receive window: clock, reset, packet
// stimulus and result-side stalls; checking is done by srw_window_checker.
// Depends on srw_pkg, selective_repeat_receive_window_core and srw_window_checker.
`timescale 1ns / 100ps

module tb_selective_repeat_receive_window_core;

   localparam int TOTAL_ITEMS      = 420;
   localparam int PHASE_ITEMS      = 60;
   localparam int MAX_GAP          = 18;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 64;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [srw_pkg::SEQ_W-1:0] req_seq_no;
   logic [srw_pkg::LEN_W-1:0] req_data_len;
   logic [srw_pkg::TAG_W-1:0] req_payload_tag;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_kind;
   logic                      rsp_accepted;
   logic [srw_pkg::SEQ_W-1:0] rsp_frame_seq;
   logic [srw_pkg::LEN_W-1:0] rsp_frame_size;
   logic [srw_pkg::TAG_W-1:0] rsp_frame_tag;
   logic                      rsp_transfer_done;
   logic                      rsp_last;

   int fail_count;
   int pending_results;

   // stimulus-side view of the window: base sequence and frames held ahead of it
   logic [srw_pkg::SEQ_W-1:0]        window_base = '0;
   logic [srw_pkg::WINDOW_SLOTS-1:0] held_ahead  = '0;
   logic [srw_pkg::SEQ_W-1:0]        burst_seqs[$];
   int items_sent     = 0;
   int send_gap_max   = MAX_GAP;
   int stall_gap_max  = MAX_GAP;
   bit hold_request   = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   selective_repeat_receive_window_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_seq_no        (req_seq_no),
      .req_data_len      (req_data_len),
      .req_payload_tag   (req_payload_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_accepted      (rsp_accepted),
      .rsp_frame_seq     (rsp_frame_seq),
      .rsp_frame_size    (rsp_frame_size),
      .rsp_frame_tag     (rsp_frame_tag),
      .rsp_transfer_done (rsp_transfer_done),
      .rsp_last          (rsp_last)
   );

   srw_window_checker window_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_seq_no        (req_seq_no),
      .req_data_len      (req_data_len),
      .req_payload_tag   (req_payload_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_accepted      (rsp_accepted),
      .rsp_frame_seq     (rsp_frame_seq),
      .rsp_frame_size    (rsp_frame_size),
      .rsp_frame_tag     (rsp_frame_tag),
      .rsp_transfer_done (rsp_transfer_done),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .pending_results   (pending_results)
   );

   // offer one packet and wait for its transfer; valid stays high afterward
   task automatic send_packet(input logic [srw_pkg::SEQ_W-1:0] seq,
                              input logic [srw_pkg::LEN_W-1:0] len,
                              input logic [srw_pkg::TAG_W-1:0] tag);
      int gap;
      int offset;
      logic [srw_pkg::SEQ_W-1:0] diff;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_seq_no      <= seq;
      req_data_len    <= len;
      req_payload_tag <= tag;
      do @(posedge clock); while (req_stall);
      items_sent++;
      diff   = seq - window_base;
      offset = diff / srw_pkg::FULL_PAYLOAD;
      if (diff % srw_pkg::FULL_PAYLOAD == 0 && offset < srw_pkg::WINDOW_SLOTS)
         held_ahead[offset] = 1'b1;
      while (held_ahead[0]) begin
         held_ahead  = held_ahead >> 1;
         window_base = srw_pkg::SEQ_W'((window_base + srw_pkg::FULL_PAYLOAD)
                                       % srw_pkg::SEQ_SPACE);
      end
   endtask

   task automatic send_frame(input int offset, input logic [srw_pkg::LEN_W-1:0] len,
                             input logic [srw_pkg::TAG_W-1:0] tag);
      send_packet(srw_pkg::SEQ_W'((window_base + offset * srw_pkg::FULL_PAYLOAD)
                                  % srw_pkg::SEQ_SPACE), len, tag);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // mostly shuffled in-window runs, some frames ahead of a gap, some that match nothing
   task automatic send_random_item();
      int pick;
      int n;
      logic [srw_pkg::SEQ_W-1:0] seq;
      logic [srw_pkg::LEN_W-1:0] len;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         if ($urandom_range(0, 1)) begin
            seq = srw_pkg::SEQ_W'($urandom);
            if (seq % srw_pkg::FULL_PAYLOAD == 0)
               seq[0] = 1'b1;
         end else begin
            seq = srw_pkg::SEQ_W'((window_base + $urandom_range(srw_pkg::WINDOW_SLOTS,
                  srw_pkg::SEQ_SPACE / srw_pkg::FULL_PAYLOAD - 1) * srw_pkg::FULL_PAYLOAD)
                  % srw_pkg::SEQ_SPACE);
         end
      end else if (pick < 22) begin
         seq = srw_pkg::SEQ_W'((window_base + $urandom_range(1, srw_pkg::WINDOW_SLOTS - 1)
                               * srw_pkg::FULL_PAYLOAD) % srw_pkg::SEQ_SPACE);
      end else begin
         if (burst_seqs.size() == 0) begin
            n = $urandom_range(1, srw_pkg::WINDOW_SLOTS);
            for (int j = 0; j < n; j++)
               burst_seqs.insert($urandom_range(0, burst_seqs.size()),
                                 srw_pkg::SEQ_W'((window_base + j * srw_pkg::FULL_PAYLOAD)
                                                 % srw_pkg::SEQ_SPACE));
         end
         seq = burst_seqs.pop_front();
      end
      pick = $urandom_range(0, 99);
      if (pick < 80)
         len = srw_pkg::LEN_W'(srw_pkg::FULL_PAYLOAD);
      else if (pick < 85)
         len = '0;
      else if (pick < 90)
         len = '1;
      else
         len = srw_pkg::LEN_W'($urandom_range(0, 2**srw_pkg::LEN_W - 1));
      send_packet(seq, len, srw_pkg::TAG_W'($urandom_range(0, 2**srw_pkg::TAG_W - 1)));
   endtask

   // result side: random stalls per transfer, one long hold when asked
   initial begin : result_stalls
      int gap;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            gap = $urandom_range(0, stall_gap_max);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock);
         while (!(rsp_valid && !rsp_stall) && !(hold_request && !hold_done));
      end
   end

   initial begin : stimulus
      int phase;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_seq_no      <= '0;
      req_data_len    <= '0;
      req_payload_tag <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // duplicate overwrite, in-order release of two
      send_frame(1, srw_pkg::LEN_W'(srw_pkg::FULL_PAYLOAD), 8'h01);
      send_frame(1, srw_pkg::LEN_W'(srw_pkg::FULL_PAYLOAD), 8'hAA);
      send_frame(0, srw_pkg::LEN_W'(srw_pkg::FULL_PAYLOAD), 8'hFF);
      // stale number, all-ones fields, unaligned number: all dropped
      send_packet(srw_pkg::SEQ_W'(window_base - srw_pkg::FULL_PAYLOAD),
                  srw_pkg::LEN_W'(srw_pkg::FULL_PAYLOAD), 8'h10);
      send_packet('1, '1, 8'h00);
      send_packet(16'h0001, '0, 8'h80);
      // fill the window back to front, short and oversized frames among them
      send_frame(srw_pkg::WINDOW_SLOTS - 1, '0, 8'h00);
      for (int k = srw_pkg::WINDOW_SLOTS - 2; k > 0; k--)
         send_frame(k, (k == 1) ? '1 : (k == 2) ? srw_pkg::LEN_W'(1) :
                    srw_pkg::LEN_W'(srw_pkg::FULL_PAYLOAD),
                    srw_pkg::TAG_W'($urandom_range(0, 2**srw_pkg::TAG_W - 1)));
      // whole window released at once, then done on a single release
      send_frame(0, srw_pkg::LEN_W'(srw_pkg::FULL_PAYLOAD), 8'h5A);
      send_frame(0, srw_pkg::LEN_W'(srw_pkg::FULL_PAYLOAD), 8'h33);
      // one past the window edge
      send_frame(srw_pkg::WINDOW_SLOTS, srw_pkg::LEN_W'(srw_pkg::FULL_PAYLOAD), 8'h77);
      wait_results_drained();

      phase = 0;
      while (items_sent < TOTAL_ITEMS) begin
         send_gap_max  = (phase % 4 == 0 || phase % 4 == 2) ? MAX_GAP : 0;
         stall_gap_max = (phase % 4 == 0 || phase % 4 == 1) ? MAX_GAP : 0;
         // long result hold while packets keep coming back to back
         if (phase == 1)
            hold_request = 1'b1;
         for (int i = 0; i < PHASE_ITEMS && items_sent < TOTAL_ITEMS; i++)
            send_random_item();
         if (phase % 2 == 0)
            wait_results_drained();
         phase++;
      end

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results == 0)
         $display("PASS selective_repeat_receive_window_core");
      else
         $display("FAIL selective_repeat_receive_window_core");
      $finish;
   end

   initial begin : watchdog
      #5ms;
      $display("FAIL selective_repeat_receive_window_core");
      $finish;
   end

endmodule
